@@ rtl/core/name_value_pair_deframer_defines.svh @@
// Assertion macros shared by the deframer checker.
// Depends on nothing; included by the checker file only.
`ifndef NAME_VALUE_PAIR_DEFRAMER_DEFINES_SVH
`define NAME_VALUE_PAIR_DEFRAMER_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define NVPD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nvpd check failed");

// Implication checked in the cycle after the antecedent.
`define NVPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nvpd check failed");

`endif

@@ rtl/core/nvpd_pkg.sv @@
// Package for the name-value pair deframer: phase and kind codes, word types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package nvpd_pkg;

    localparam int unsigned LEN_W = 31;

    typedef enum logic [2:0] {
        PH_NLEN      = 3'd0,
        PH_NLEN_MORE = 3'd1,
        PH_VLEN      = 3'd2,
        PH_VLEN_MORE = 3'd3,
        PH_NAME      = 3'd4,
        PH_VALUE     = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_LEN   = 3'd0,
        KIND_NAME  = 3'd1,
        KIND_VALUE = 3'd2,
        KIND_END   = 3'd3,
        KIND_ERR   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       stream_end;
    } item_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data_out;
        logic [LEN_W-1:0] offset;
        logic             pair_done;
        logic [LEN_W-1:0] name_len;
        logic [LEN_W-1:0] value_len;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/nvpd_in_stage.sv @@
// Input register of the deframer: holds one accepted word until the core takes it.
// Depends on nvpd_pkg.
`default_nettype none

module nvpd_in_stage
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire nvpd_pkg::item_t in_item,
    input  wire logic           advance,
    output logic                item_valid,
    output nvpd_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    nvpd_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nvpd_core.sv @@
// Parser state and next-state logic: decodes lengths and tags each word.
// Depends on nvpd_pkg.
`default_nettype none

module nvpd_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire nvpd_pkg::item_t item,
    output nvpd_pkg::result_t    result
);

    localparam int unsigned W = nvpd_pkg::LEN_W;

    nvpd_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       left_reg, left_next;
    logic [W-1:0]     accum_reg, accum_next;
    logic [W-1:0]     nlen_reg, nlen_next;
    logic [W-1:0]     vlen_reg, vlen_next;
    logic [W-1:0]     pos_reg, pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nvpd_pkg::PH_NLEN;
            left_reg  <= '0;
            accum_reg <= '0;
            nlen_reg  <= '0;
            vlen_reg  <= '0;
            pos_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            accum_reg <= accum_next;
            nlen_reg  <= nlen_next;
            vlen_reg  <= vlen_next;
            pos_reg   <= pos_next;
        end
    end

    always_comb
    begin
        logic         known;
        logic [W-1:0] acc;
        logic [W:0]   pos_inc;
        logic [7:0]   b;

        b          = item.byte_in;
        known      = 1'b0;
        acc        = {accum_reg[W-9:0], b};
        pos_inc    = {1'b0, pos_reg} + {{W{1'b0}}, 1'b1};
        phase_next = phase_reg;
        left_next  = left_reg;
        accum_next = accum_reg;
        nlen_next  = nlen_reg;
        vlen_next  = vlen_reg;
        pos_next   = pos_reg;
        result.kind      = nvpd_pkg::KIND_LEN;
        result.data_out  = '0;
        result.offset    = '0;
        result.pair_done = 1'b0;

        if (item.stream_end)
        begin
            result.kind = (phase_reg == nvpd_pkg::PH_NLEN) ? nvpd_pkg::KIND_END
                                                           : nvpd_pkg::KIND_ERR;
            phase_next = nvpd_pkg::PH_NLEN;
            left_next  = '0;
            accum_next = '0;
            nlen_next  = '0;
            vlen_next  = '0;
            pos_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                nvpd_pkg::PH_NLEN, nvpd_pkg::PH_VLEN:
                begin
                    result.data_out = b;
                    if (phase_reg == nvpd_pkg::PH_NLEN)
                    begin
                        nlen_next = '0;
                        vlen_next = '0;
                    end
                    if (b[7])
                    begin
                        accum_next = {{(W-7){1'b0}}, b[6:0]};
                        left_next  = 2'd3;
                        phase_next = (phase_reg == nvpd_pkg::PH_VLEN) ?
                                     nvpd_pkg::PH_VLEN_MORE : nvpd_pkg::PH_NLEN_MORE;
                    end
                    else if (phase_reg == nvpd_pkg::PH_VLEN)
                    begin
                        vlen_next = {{(W-8){1'b0}}, b};
                        known     = 1'b1;
                    end
                    else
                    begin
                        nlen_next  = {{(W-8){1'b0}}, b};
                        phase_next = nvpd_pkg::PH_VLEN;
                    end
                end
                nvpd_pkg::PH_NLEN_MORE, nvpd_pkg::PH_VLEN_MORE:
                begin
                    result.data_out = b;
                    if (left_reg <= 2'd1)
                    begin
                        left_next  = '0;
                        accum_next = '0;
                        if (phase_reg == nvpd_pkg::PH_VLEN_MORE)
                        begin
                            vlen_next = acc;
                            known     = 1'b1;
                        end
                        else
                        begin
                            nlen_next  = acc;
                            phase_next = nvpd_pkg::PH_VLEN;
                        end
                    end
                    else
                    begin
                        left_next  = left_reg - 2'd1;
                        accum_next = acc;
                    end
                end
                nvpd_pkg::PH_NAME:
                begin
                    result.kind     = nvpd_pkg::KIND_NAME;
                    result.data_out = b;
                    result.offset   = pos_reg;
                    if (pos_inc >= {1'b0, nlen_reg})
                    begin
                        pos_next = '0;
                        if (vlen_reg == '0)
                        begin
                            result.pair_done = 1'b1;
                            phase_next       = nvpd_pkg::PH_NLEN;
                        end
                        else
                        begin
                            phase_next = nvpd_pkg::PH_VALUE;
                        end
                    end
                    else
                    begin
                        pos_next = pos_inc[W-1:0];
                    end
                end
                nvpd_pkg::PH_VALUE:
                begin
                    result.kind     = nvpd_pkg::KIND_VALUE;
                    result.data_out = b;
                    result.offset   = pos_reg;
                    if (pos_inc >= {1'b0, vlen_reg})
                    begin
                        pos_next         = '0;
                        result.pair_done = 1'b1;
                        phase_next       = nvpd_pkg::PH_NLEN;
                    end
                    else
                    begin
                        pos_next = pos_inc[W-1:0];
                    end
                end
                default:
                begin
                    phase_next = nvpd_pkg::PH_NLEN;
                    left_next  = '0;
                    accum_next = '0;
                    nlen_next  = '0;
                    vlen_next  = '0;
                    pos_next   = '0;
                end
            endcase

            if (known)
            begin
                pos_next = '0;
                if (nlen_next != '0)
                begin
                    phase_next = nvpd_pkg::PH_NAME;
                end
                else if (vlen_next != '0)
                begin
                    phase_next = nvpd_pkg::PH_VALUE;
                end
                else
                begin
                    phase_next       = nvpd_pkg::PH_NLEN;
                    result.pair_done = 1'b1;
                end
            end
        end

        result.name_len  = nlen_next;
        result.value_len = vlen_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/nvpd_out_stage.sv @@
// Result register of the deframer: holds a tagged word until the receiver takes it.
// Depends on nvpd_pkg.
`default_nettype none

module nvpd_out_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire nvpd_pkg::result_t load_result,
    output logic                   free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output nvpd_pkg::result_t      out_result
);

    logic              valid_reg;
    logic              valid_next;
    nvpd_pkg::result_t result_reg;

    assign free       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/name_value_pair_deframer.sv @@
// Name-value pair deframer, top level.
//
// Input stream s_*: one word per stream byte, or an end-of-stream word with
// s_tuser set. Output stream m_*: one tagged word per input word: kind in
// m_tuser (length, name byte, value byte, clean end, truncation error),
// the byte with its offset and the current name and value lengths in
// m_tdata, and m_tlast on the last word of each pair.
// Path: an accepted word waits in the input register, the parser step tags
// it, and the result register holds the tagged word for the receiver.
// Throughput: one word per cycle while m_tready stays high, set by the single
// parser step between the two registers.
// Reset: the parser returns to expecting a name length, all lengths clear,
// both registers empty. An end-of-stream word does the same to the parser.
// Receiver stall: the result register holds its word; the input register
// takes one more word if it is empty, then s_tready drops until the
// receiver takes the held result.
// Depends on nvpd_pkg, nvpd_in_stage, nvpd_core, nvpd_out_stage.
`default_nettype none

module name_value_pair_deframer
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,  // [7:0] byte_in
    input  wire logic         s_tuser,  // [0] stream_end
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,  // [7:0] data_out, [38:8] offset,
                                        // [69:39] name_len, [100:70] value_len
    output logic [2:0]        m_tuser,  // [2:0] kind
    output logic              m_tlast   // pair_done
);

    nvpd_pkg::item_t   in_item;
    nvpd_pkg::item_t   item;
    nvpd_pkg::result_t step_result;
    nvpd_pkg::result_t out_result;
    logic              item_valid;
    logic              out_free;
    logic              advance;

    assign in_item.byte_in    = s_tdata;
    assign in_item.stream_end = s_tuser;
    assign advance            = item_valid && out_free;

    nvpd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    nvpd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (step_result)
    );

    nvpd_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .load_result (step_result),
        .free        (out_free),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    assign m_tdata = {3'b000, out_result.value_len, out_result.name_len,
                      out_result.offset, out_result.data_out};
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.pair_done;

endmodule

`default_nettype wire

@@ rtl/core/nvpd_checker.sv @@
// Port-level checks of the deframer, bound to the top level.
// Depends on nvpd_pkg and name_value_pair_deframer_defines.svh.
`default_nettype none
`include "name_value_pair_deframer_defines.svh"

module nvpd_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata,
    input wire logic [2:0]   m_tuser,
    input wire logic         m_tlast
);

    logic         is_stop;
    logic         is_data;
    logic         name_done;
    logic [107:0] out_word;

    assign is_stop = m_tvalid && (m_tuser == nvpd_pkg::KIND_END ||
                                  m_tuser == nvpd_pkg::KIND_ERR);
    assign is_data = m_tvalid && (m_tuser == nvpd_pkg::KIND_NAME ||
                                  m_tuser == nvpd_pkg::KIND_VALUE);
    assign name_done = m_tvalid && m_tlast && m_tuser == nvpd_pkg::KIND_NAME;
    assign out_word  = {m_tdata, m_tuser, m_tlast};

    `NVPD_ASSERT_IMPLIES(a_stop_clears, clk, rst_n, is_stop, m_tdata == '0 && !m_tlast)
    `NVPD_ASSERT_IMPLIES(a_len_offset_zero, clk, rst_n, m_tvalid && !is_data, m_tdata[38:8] == '0)
    `NVPD_ASSERT_IMPLIES(a_name_done_no_value, clk, rst_n, name_done, m_tdata[100:70] == '0)
    `NVPD_ASSERT_IMPLIES(a_ready_when_empty, clk, rst_n, s_tvalid && !m_tvalid, s_tready)
    `NVPD_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

endmodule

bind name_value_pair_deframer nvpd_checker u_nvpd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ test/tb_name_value_pair_deframer.sv @@
`timescale 1ns / 100ps
// Self-checking bench for name_value_pair_deframer: streams of length, name and value bytes
// with clean and truncated ends, checked word by word against a parser model kept here.
// Depends on nvpd_pkg and the deframer RTL.

module tb_name_value_pair_deframer;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        bit         drain;
    } stream_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    stream_word_t      pending_words[$];
    nvpd_pkg::result_t tagged_due[$];
    bit                drain_next;
    bit                word_sent;
    int                words_in, words_out, clean_ends, truncations, pairs_closed, faults;

    nvpd_pkg::phase_t  ph;
    logic [1:0]        left;
    logic [30:0]       acc, nlen, vlen, pos;

    name_value_pair_deframer dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic void clear_parser();
        ph = nvpd_pkg::PH_NLEN;
        left = 2'd0;
        acc = '0;
        nlen = '0;
        vlen = '0;
        pos = '0;
    endfunction

    function automatic logic enter_data();
        pos = '0;
        if (nlen != '0)
        begin
            ph = nvpd_pkg::PH_NAME;
            return 1'b0;
        end
        if (vlen != '0)
        begin
            ph = nvpd_pkg::PH_VALUE;
            return 1'b0;
        end
        ph = nvpd_pkg::PH_NLEN;
        return 1'b1;
    endfunction

    function automatic nvpd_pkg::result_t parse_word(input logic [7:0] b, input logic fin);
        nvpd_pkg::result_t r;
        logic              is_val;
        r.kind = nvpd_pkg::KIND_LEN;
        r.data_out = 8'h00;
        r.offset = '0;
        r.pair_done = 1'b0;
        if (fin)
        begin
            if (ph == nvpd_pkg::PH_NLEN)
                r.kind = nvpd_pkg::KIND_END;
            else
                r.kind = nvpd_pkg::KIND_ERR;
            clear_parser();
        end
        else
        begin
            case (ph)
                nvpd_pkg::PH_NLEN, nvpd_pkg::PH_VLEN:
                begin
                    is_val = (ph == nvpd_pkg::PH_VLEN);
                    r.data_out = b;
                    if (!is_val)
                    begin
                        nlen = '0;
                        vlen = '0;
                    end
                    if (b[7])
                    begin
                        acc = {24'd0, b[6:0]};
                        left = 2'd3;
                        if (is_val)
                            ph = nvpd_pkg::PH_VLEN_MORE;
                        else
                            ph = nvpd_pkg::PH_NLEN_MORE;
                    end
                    else if (is_val)
                    begin
                        vlen = {23'd0, b};
                        r.pair_done = enter_data();
                    end
                    else
                    begin
                        nlen = {23'd0, b};
                        ph = nvpd_pkg::PH_VLEN;
                    end
                end
                nvpd_pkg::PH_NLEN_MORE, nvpd_pkg::PH_VLEN_MORE:
                begin
                    is_val = (ph == nvpd_pkg::PH_VLEN_MORE);
                    r.data_out = b;
                    acc = {acc[22:0], b};
                    if (left <= 2'd1)
                    begin
                        left = 2'd0;
                        if (is_val)
                        begin
                            vlen = acc;
                            acc = '0;
                            r.pair_done = enter_data();
                        end
                        else
                        begin
                            nlen = acc;
                            acc = '0;
                            ph = nvpd_pkg::PH_VLEN;
                        end
                    end
                    else
                        left = left - 2'd1;
                end
                nvpd_pkg::PH_NAME:
                begin
                    r.kind = nvpd_pkg::KIND_NAME;
                    r.data_out = b;
                    r.offset = pos;
                    if ({1'b0, pos} + 32'd1 >= {1'b0, nlen})
                    begin
                        pos = '0;
                        if (vlen == '0)
                        begin
                            r.pair_done = 1'b1;
                            ph = nvpd_pkg::PH_NLEN;
                        end
                        else
                            ph = nvpd_pkg::PH_VALUE;
                    end
                    else
                        pos = pos + 31'd1;
                end
                nvpd_pkg::PH_VALUE:
                begin
                    r.kind = nvpd_pkg::KIND_VALUE;
                    r.data_out = b;
                    r.offset = pos;
                    if ({1'b0, pos} + 32'd1 >= {1'b0, vlen})
                    begin
                        pos = '0;
                        r.pair_done = 1'b1;
                        ph = nvpd_pkg::PH_NLEN;
                    end
                    else
                        pos = pos + 31'd1;
                end
                default:
                    clear_parser();
            endcase
        end
        r.name_len = nlen;
        r.value_len = vlen;
        return r;
    endfunction

    task automatic add_word(input logic [7:0] b, input logic fin);
        stream_word_t w;
        w.b = b;
        w.fin = fin;
        w.drain = drain_next;
        drain_next = 1'b0;
        pending_words.push_back(w);
    endtask

    task automatic add_end();
        add_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic encode_len(input logic [30:0] len, input bit long_form, ref logic [7:0] q[$]);
        if (long_form || len > 31'd127)
        begin
            q.push_back({1'b1, len[30:24]});
            q.push_back(len[23:16]);
            q.push_back(len[15:8]);
            q.push_back(len[7:0]);
        end
        else
            q.push_back(len[7:0]);
    endtask

    // keep < 0 sends the whole pair, otherwise only its first keep bytes
    task automatic add_pair(input int n, input int v, input int keep);
        logic [7:0] q[$];
        encode_len(31'(n), $urandom_range(0, 3) == 0, q);
        encode_len(31'(v), $urandom_range(0, 3) == 0, q);
        repeat (n + v) q.push_back(8'($urandom_range(0, 255)));
        if (keep >= 0 && keep < q.size())
            q = q[0:keep-1];
        foreach (q[i])
            add_word(q[i], 1'b0);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 0;
        if (r < 9)
            return $urandom_range(1, 6);
        return $urandom_range(7, 40);
    endfunction

    task automatic flag_field(input string fld, input logic [31:0] want, input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fld, want, got);
        faults++;
    endtask

    always @(posedge clk)
    begin
        nvpd_pkg::result_t want, got;
        if (rst_n && s_tvalid && s_tready)
        begin
            tagged_due.push_back(parse_word(s_tdata, s_tuser));
            word_sent = 1'b1;
            words_in++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            words_out++;
            got.kind = nvpd_pkg::kind_t'(m_tuser);
            got.data_out = m_tdata[7:0];
            got.offset = m_tdata[38:8];
            got.name_len = m_tdata[69:39];
            got.value_len = m_tdata[100:70];
            got.pair_done = m_tlast;
            if (tagged_due.size() == 0)
            begin
                $display("%0t ns: unexpected word, expected none, actual kind %0d data 0x%0h",
                         $time, m_tuser, m_tdata);
                faults++;
            end
            else
            begin
                want = tagged_due.pop_front();
                if (want.kind == nvpd_pkg::KIND_END)
                    clean_ends++;
                if (want.kind == nvpd_pkg::KIND_ERR)
                    truncations++;
                if (want.pair_done)
                    pairs_closed++;
                if (got.kind !== want.kind)
                    flag_field("kind", want.kind, got.kind);
                if (got.data_out !== want.data_out)
                    flag_field("data_out", want.data_out, got.data_out);
                if (got.offset !== want.offset)
                    flag_field("offset", want.offset, got.offset);
                if (got.pair_done !== want.pair_done)
                    flag_field("pair_done", want.pair_done, got.pair_done);
                if (got.name_len !== want.name_len)
                    flag_field("name_len", want.name_len, got.name_len);
                if (got.value_len !== want.value_len)
                    flag_field("value_len", want.value_len, got.value_len);
            end
        end
    end

    always @(negedge clk)
    begin
        bit calm;
        stream_word_t w;
        calm = (words_in >= 150 && words_in < 280);
        if (rst_n && (!s_tvalid || word_sent))
        begin
            word_sent = 1'b0;
            if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 23) &&
                !(pending_words[0].drain && tagged_due.size() != 0))
            begin
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= w.b;
                s_tuser <= w.fin;
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= calm || ($urandom_range(0, 99) >= 23);
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int  r, n;
        bit  mid_drain;
        clear_parser();
        drain_next = 1'b0;
        mid_drain = 1'b0;

        // clean end at start, empty pair, empty value, empty name
        add_word(8'hff, 1'b1);
        add_word(8'h00, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h01, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'hff, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h01, 1'b0);
        add_word(8'h00, 1'b0);
        // long form holding a small name length, empty value
        add_word(8'h80, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h02, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'ha5, 1'b0);
        add_word(8'h5a, 1'b0);
        // largest name length, then a truncated stream
        add_word(8'hff, 1'b0);
        add_word(8'hff, 1'b0);
        add_word(8'hff, 1'b0);
        add_word(8'hff, 1'b0);
        add_word(8'h7f, 1'b0);
        add_word(8'h55, 1'b0);
        add_word(8'h00, 1'b1);
        add_word(8'h00, 1'b1);

        drain_next = 1'b1;
        while (pending_words.size() < 440)
        begin
            if (!mid_drain && pending_words.size() >= 250)
            begin
                drain_next = 1'b1;
                mid_drain = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                repeat ($urandom_range(1, 4)) add_pair(pick_len(), pick_len(), -1);
                if ($urandom_range(0, 4) != 0)
                    add_end();
            end
            else if (r < 85)
            begin
                n = pick_len();
                add_pair(n, pick_len(), $urandom_range(1, n + 4));
                add_end();
            end
            else if (r < 95)
            begin
                add_word({1'b1, 7'($urandom_range(0, 127))}, 1'b0);
                repeat (3) add_word(8'($urandom_range(0, 255)), 1'b0);
                repeat ($urandom_range(0, 6)) add_word(8'($urandom_range(0, 255)), 1'b0);
                add_end();
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                    add_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                add_end();
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || s_tvalid)
            @(posedge clk);
        while (tagged_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d words in, %0d words out, %0d pairs closed.",
                 words_in, words_out, pairs_closed);
        $display("Streams ended cleanly %0d times and by truncation %0d times.",
                 clean_ends, truncations);
        if (faults == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/nvpd_pkg.sv
rtl/core/nvpd_in_stage.sv
rtl/core/nvpd_core.sv
rtl/core/nvpd_out_stage.sv
rtl/core/name_value_pair_deframer.sv
rtl/core/nvpd_checker.sv
test/tb_name_value_pair_deframer.sv
